// File: rtl/mwr_pkg.sv
// Shared types, frame constants and the CRC-16 byte update for the write-register framer.
`default_nettype none

package mwr_pkg;

	// Fixed frame contents
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0]  ADDR_HIGH_FIXED   = 8'h20;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [7:0]  DEV_ADDR_RESET    = 8'h01;

	// Byte positions within the frame, in transmit order
	localparam logic [2:0] POS_DEV     = 3'd0;
	localparam logic [2:0] POS_FUNC    = 3'd1;
	localparam logic [2:0] POS_ADDR_HI = 3'd2;
	localparam logic [2:0] POS_ADDR_LO = 3'd3;
	localparam logic [2:0] POS_VAL_HI  = 3'd4;
	localparam logic [2:0] POS_VAL_LO  = 3'd5;
	localparam logic [2:0] POS_CRC_LO  = 3'd6;
	localparam logic [2:0] POS_CRC_HI  = 3'd7;

	// One queued request, with the device address captured at acceptance
	typedef struct packed {
		logic [7:0]  dev_addr;
		logic [7:0]  reg_low;
		logic [15:0] value;
	} mwr_entry_t;

	// CRC-16/MODBUS: fold one byte into the running CRC, reflected, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mwr_front.sv
// Front end: device address register, request intake and a two-entry request queue.
`default_nettype none

module mwr_front import mwr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  register_low,
	input  wire logic [15:0] write_value,
	input  wire logic        pop,
	output logic             entry_valid,
	output mwr_entry_t       entry
);

	logic [7:0]  dev_addr_q;
	mwr_entry_t  queue_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        do_pop;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_valid) begin
			dev_addr_q <= cfg_data;
		end
	end

	// Queue handshakes
	assign in_ready    = (count_q != 2'd2);
	assign push        = in_valid && in_ready;
	assign entry_valid = (count_q != 2'd0);
	assign do_pop      = pop && entry_valid;
	assign entry       = queue_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage, payload only
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{dev_addr: dev_addr_q, reg_low: register_low,
				value: write_value};
		end
	end

endmodule

`default_nettype wire

// File: rtl/mwr_back.sv
// Back end: serialises one queued request into eight frame bytes with a running CRC.
`default_nettype none

module mwr_back import mwr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        entry_valid,
	input  wire mwr_entry_t  entry,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_byte
);

	logic [2:0]  pos_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        load;
	logic [7:0]  next_byte;

	// Output register takes a new byte when empty or being drained
	assign load = entry_valid && (!out_valid_q || out_ready);
	assign pop  = load && (pos_q == POS_CRC_HI);

	// Byte for the current position
	always_comb begin
		case (pos_q)
			POS_DEV:     next_byte = entry.dev_addr;
			POS_FUNC:    next_byte = FUNC_WRITE_SINGLE;
			POS_ADDR_HI: next_byte = ADDR_HIGH_FIXED;
			POS_ADDR_LO: next_byte = entry.reg_low;
			POS_VAL_HI:  next_byte = entry.value[15:8];
			POS_VAL_LO:  next_byte = entry.value[7:0];
			POS_CRC_LO:  next_byte = crc_q[7:0];
			POS_CRC_HI:  next_byte = crc_q[15:8];
			default:     next_byte = 8'h00;
		endcase
	end

	// Position counter, CRC accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_DEV;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q       <= pos_q + 3'd1;
				if (pos_q == POS_CRC_HI) begin
					crc_q <= CRC_INIT;
				end else if (pos_q != POS_CRC_LO) begin
					crc_q <= crc16_byte(crc_q, next_byte);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= next_byte;
			last_q <= (pos_q == POS_CRC_HI);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

endmodule

`default_nettype wire

// File: rtl/modbus_write_register_framer.sv
// Top level of the Modbus RTU write-single-register framer.
//
//   channel | signals                                   | dir | beat
//   cfg     | cfg_valid, cfg_ready, cfg_data[7:0]       | in  | device address
//   in      | in_valid, in_ready, register_low, write_value | in | one request
//   out     | out_valid, out_ready, frame_byte, last_byte | out | one frame byte
//
// Each request yields eight output beats, one per cycle while out_ready stays high;
// the byte serialiser in the back end sets that rate.
// The first byte is loaded from the queue into the output register.
// A two-entry queue lets requests be taken while a frame is still being sent.
// Reset sets the device address to 1 and empties queue and output register.
// Device address is captured per request at acceptance.
`default_nettype none

module modbus_write_register_framer import mwr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  register_low,
	input  wire logic [15:0] write_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_byte
);

	logic       entry_valid;
	logic       pop;
	mwr_entry_t entry;

	mwr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.register_low (register_low),
		.write_value  (write_value),
		.pop          (pop),
		.entry_valid  (entry_valid),
		.entry        (entry)
	);

	mwr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.entry       (entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

endmodule

`default_nettype wire

// File: rtl/mwr_chk.sv
// Port-level checker for the framer, bound to the top level.
`default_nettype none

module mwr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  frame_byte,
	input wire logic        last_byte
);

	logic [2:0] beat_q;
	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;
	logic       frame_done;

	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign frame_done = out_acc && last_byte;

	// Beat position within the frame and requests not yet fully sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q    <= 3'd0;
			pending_q <= 3'd0;
		end else begin
			if (out_acc) begin
				beat_q <= beat_q + 3'd1;
			end
			if (in_acc && !frame_done) begin
				pending_q <= pending_q + 3'd1;
			end else if (frame_done && !in_acc) begin
				pending_q <= pending_q - 3'd1;
			end
		end
	end

	// A stalled beat holds its byte
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
		else $error("stalled output beat changed");

	// last_byte marks exactly every eighth beat
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_byte == (beat_q == 3'd7)))
		else $error("last_byte out of place");

	// No output without an outstanding request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 3'd0))
		else $error("output beat without a request");

	// Idle block takes requests
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 3'd0) |-> in_ready)
		else $error("idle block not ready");

endmodule

bind modbus_write_register_framer mwr_chk u_mwr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frame_byte (frame_byte),
	.last_byte  (last_byte)
);

`default_nettype wire
